// File: rtl/rvde_pkg.sv
// ============================================================================
// RV64IM decode/execute package
// Opcodes, CSR addresses, result codes, state types and shared helpers.
// ============================================================================
package rvde_pkg;

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3b;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1b;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    // Whole-word system instructions.
    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INS_MRET   = 32'h3020_0073;

    // CSR funct3 codes.
    localparam logic [2:0] CSR_RW  = 3'd1;
    localparam logic [2:0] CSR_RS  = 3'd2;
    localparam logic [2:0] CSR_RSI = 3'd6;
    localparam logic [2:0] CSR_RCI = 3'd7;

    // Machine CSR addresses.
    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MIE     = 12'h304;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [11:0] CSR_MIP     = 12'h344;

    // mstatus bit positions and the environment-call cause.
    localparam int MSTATUS_MIE  = 3;
    localparam int MSTATUS_MPIE = 7;
    localparam int MSTATUS_MPP  = 11;
    localparam logic [63:0] CAUSE_ECALL_M = 64'h0b;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_EBREAK  = 2'd1;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    // Request from the sequencer to the multiply/divide unit.
    typedef struct packed {
        logic       start;
        logic [2:0] funct3;
        logic       word;
    } md_req_t;

    typedef struct packed {
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [63:0] rd_value;
        logic [63:0] next_pc;
        logic [1:0]  mem_op;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_signed;
        logic [63:0] store_data;
        logic [1:0]  trap_kind;
    } res_t;

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

endpackage

// File: rtl/rvde_in_if.sv
// ============================================================================
// Instruction channel
// Valid/ready channel carrying one instruction with its pc and operands.
// ============================================================================
interface rvde_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [63:0] pc;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;

    modport source(output valid, instruction, pc, rs1_value, rs2_value, input ready);
    modport sink(input valid, instruction, pc, rs1_value, rs2_value, output ready);
endinterface

// File: rtl/rvde_out_if.sv
// ============================================================================
// Result channel
// Valid/ready channel carrying the outcome of one executed instruction.
// ============================================================================
interface rvde_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [63:0] rd_value;
    logic [63:0] next_pc;
    logic [1:0]  mem_op;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_log2;
    logic        load_signed;
    logic [63:0] store_data;
    logic [1:0]  trap_kind;

    modport source(output valid, rd_index, rd_write, rd_value, next_pc, mem_op, mem_address,
                   mem_size_log2, load_signed, store_data, trap_kind, input ready);
    modport sink(input valid, rd_index, rd_write, rd_value, next_pc, mem_op, mem_address,
                 mem_size_log2, load_signed, store_data, trap_kind, output ready);
endinterface

// File: rtl/rvde_muldiv.sv
// ============================================================================
// Iterative multiply/divide unit
// Shift-add multiplier and restoring divider sharing one set of 64-bit registers,
// one bit per cycle, with sign fix-up and word sign extension at the end.
// ============================================================================
module rvde_muldiv
(
    input  logic             clk,
    input  logic             rst_n,
    input  rvde_pkg::md_req_t req,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    output logic             done,
    output logic [63:0]      result
);

    rvde_pkg::md_state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [63:0] hi_reg, lo_reg, mcand_reg, dividend_reg;
    logic [2:0]  f3_reg;
    logic        word_reg, neg_q_reg, neg_r_reg, dz_reg;
    logic        done_reg;
    logic [63:0] result_reg;

    logic        sa, sb, na, nb;
    logic [63:0] wa, wb, ua, ub;
    logic [64:0] mul_sum;
    logic [64:0] div_shift;
    logic [65:0] div_diff;
    logic [63:0] fix_val;

    // Operand preparation at start.
    always_comb
    begin
        if (req.funct3[2])
        begin
            sa = ~req.funct3[0];
            sb = ~req.funct3[0];
        end
        else
        begin
            sa = (req.funct3 == 3'd1) || (req.funct3 == 3'd2);
            sb = (req.funct3 == 3'd1);
        end
        if (req.word)
        begin
            wa = sa ? rvde_pkg::sx32(a) : {32'b0, a[31:0]};
            wb = sb ? rvde_pkg::sx32(b) : {32'b0, b[31:0]};
        end
        else
        begin
            wa = a;
            wb = b;
        end
        na = sa & wa[63];
        nb = sb & wb[63];
        ua = na ? (64'd0 - wa) : wa;
        ub = nb ? (64'd0 - wb) : wb;
    end

    // One step of the shared datapath.
    always_comb
    begin
        mul_sum   = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? mcand_reg : 64'd0)};
        div_shift = {hi_reg, lo_reg[63]};
        div_diff  = {1'b0, div_shift} - {2'b00, mcand_reg};
    end

    // Sign correction of the finished product, quotient or remainder.
    always_comb
    begin
        if (!f3_reg[2])
        begin
            if (f3_reg == 3'd0)
                fix_val = neg_q_reg ? (64'd0 - lo_reg) : lo_reg;
            else
                fix_val = neg_q_reg ? (~hi_reg + {63'd0, (lo_reg == 64'd0)}) : hi_reg;
        end
        else if (dz_reg)
        begin
            fix_val = f3_reg[1] ? dividend_reg : '1;
        end
        else if (f3_reg[1])
        begin
            fix_val = neg_r_reg ? (64'd0 - hi_reg) : hi_reg;
        end
        else
        begin
            fix_val = neg_q_reg ? (64'd0 - lo_reg) : lo_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rvde_pkg::MD_IDLE:
                if (req.start)
                    state_next = rvde_pkg::MD_RUN;
            rvde_pkg::MD_RUN:
                if (cnt_reg == '1)
                    state_next = rvde_pkg::MD_FIX;
            rvde_pkg::MD_FIX:
                state_next = rvde_pkg::MD_IDLE;
            default:
                state_next = rvde_pkg::MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rvde_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == rvde_pkg::MD_FIX);
            if (state_reg == rvde_pkg::MD_RUN)
                cnt_reg <= cnt_reg + 6'd1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rvde_pkg::MD_IDLE && req.start)
        begin
            f3_reg       <= req.funct3;
            word_reg     <= req.word;
            dividend_reg <= wa;
            dz_reg       <= (wb == 64'd0);
            neg_q_reg    <= na ^ nb;
            neg_r_reg    <= na;
            hi_reg       <= '0;
            if (req.funct3[2])
            begin
                lo_reg    <= ua;
                mcand_reg <= ub;
            end
            else
            begin
                lo_reg    <= ub;
                mcand_reg <= ua;
            end
        end
        else if (state_reg == rvde_pkg::MD_RUN)
        begin
            if (!f3_reg[2])
            begin
                hi_reg <= mul_sum[64:1];
                lo_reg <= {mul_sum[0], lo_reg[63:1]};
            end
            else if (!div_diff[65])
            begin
                hi_reg <= div_diff[63:0];
                lo_reg <= {lo_reg[62:0], 1'b1};
            end
            else
            begin
                hi_reg <= div_shift[63:0];
                lo_reg <= {lo_reg[62:0], 1'b0};
            end
        end
        else if (state_reg == rvde_pkg::MD_FIX)
        begin
            result_reg <= word_reg ? rvde_pkg::sx32(fix_val) : fix_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/rv64im_decode_execute.sv
// ============================================================================
// RV64IM decode and execute unit
// Decodes and executes one instruction per item and keeps six machine CSRs.
// ============================================================================
// The block takes one item at a time: an instruction word, its pc and the two
// source register values. It answers with one result item holding the
// destination register write, the next pc, any load or store request and a
// trap code. Most instructions go through capture, execute and output, and
// the result is offered in the output state. Multiply,
// divide and remainder, including the word forms, go through one shared
// shift-add and restoring-divide unit that handles one bit per cycle. Those
// items wait for the unit through its 64 steps, a sign fix-up step and a
// registered done flag; that 64-step loop sets the worst-case rate. The input
// is not ready again until the previous result item has been
// taken. The CSRs mstatus, mie, mtvec, mepc, mcause and mip are cleared by
// reset and are changed by CSR instructions, ecall and mret; illegal
// encodings change nothing and report an illegal-instruction trap with next
// pc equal to pc.
// ============================================================================
module rv64im_decode_execute
(
    input  logic        clk,
    input  logic        rst_n,
    rvde_in_if.sink     req,
    rvde_out_if.source  rsp
);

    rvde_pkg::state_t state_reg, state_next;

    // Captured input item.
    logic [31:0] ins_reg;
    logic [63:0] pc_reg, a_reg, b_reg;

    // Machine CSRs.
    logic [63:0] mstatus_reg, mie_reg, mtvec_reg, mepc_reg, mcause_reg, mip_reg;
    logic [63:0] mstatus_next, mie_next, mtvec_next, mepc_next, mcause_next, mip_next;

    rvde_pkg::res_t res_reg, dec_res;
    logic           use_md;
    rvde_pkg::md_req_t md_req;
    logic           md_done;
    logic [63:0]    md_result;

    // Decode fields.
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [5:0]  f6;
    logic [4:0]  rd, zimm;
    logic [11:0] csr_addr;
    logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [5:0]  sh6, bs6;
    logic [4:0]  sh5, bs5;
    logic [63:0] a, b, a32, v, csr_old, csr_new;
    logic        wr, ill, has_rd, take, csr_ok;

    always_comb
    begin
        a        = a_reg;
        b        = b_reg;
        op       = ins_reg[6:0];
        f3       = ins_reg[14:12];
        f7       = ins_reg[31:25];
        f6       = ins_reg[31:26];
        rd       = ins_reg[11:7];
        zimm     = ins_reg[19:15];
        csr_addr = ins_reg[31:20];
        imm_i    = {{52{ins_reg[31]}}, ins_reg[31:20]};
        imm_s    = {{52{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
        imm_b    = {{52{ins_reg[31]}}, ins_reg[7], ins_reg[30:25], ins_reg[11:8], 1'b0};
        imm_j    = {{44{ins_reg[31]}}, ins_reg[19:12], ins_reg[20], ins_reg[30:21], 1'b0};
        imm_u    = {{32{ins_reg[31]}}, ins_reg[31:12], 12'd0};
        sh6      = ins_reg[25:20];
        sh5      = ins_reg[24:20];
        bs6      = b_reg[5:0];
        bs5      = b_reg[4:0];
        a32      = {32'd0, a_reg[31:0]};

        dec_res         = '0;
        dec_res.next_pc = pc_reg + 64'd4;
        wr      = 1'b0;
        ill     = 1'b0;
        has_rd  = 1'b1;
        take    = 1'b0;
        use_md  = 1'b0;
        v       = '0;

        mstatus_next = mstatus_reg;
        mie_next     = mie_reg;
        mtvec_next   = mtvec_reg;
        mepc_next    = mepc_reg;
        mcause_next  = mcause_reg;
        mip_next     = mip_reg;

        // Current value of the addressed CSR.
        csr_ok = 1'b1;
        unique case (csr_addr)
            rvde_pkg::CSR_MSTATUS: csr_old = mstatus_reg;
            rvde_pkg::CSR_MIE:     csr_old = mie_reg;
            rvde_pkg::CSR_MTVEC:   csr_old = mtvec_reg;
            rvde_pkg::CSR_MEPC:    csr_old = mepc_reg;
            rvde_pkg::CSR_MCAUSE:  csr_old = mcause_reg;
            rvde_pkg::CSR_MIP:     csr_old = mip_reg;
            default:
            begin
                csr_old = '0;
                csr_ok  = 1'b0;
            end
        endcase
        csr_new = csr_old;

        unique case (op)
            rvde_pkg::OP_REG:
            begin
                wr = 1'b1;
                if (f7 == rvde_pkg::F7_BASE)
                begin
                    unique case (f3)
                        3'd0: v = a + b;
                        3'd1: v = a << bs6;
                        3'd2: v = {63'd0, ($signed(a) < $signed(b))};
                        3'd3: v = {63'd0, (a < b)};
                        3'd4: v = a ^ b;
                        3'd5: v = a >> bs6;
                        3'd6: v = a | b;
                        default: v = a & b;
                    endcase
                end
                else if (f7 == rvde_pkg::F7_ALT && f3 == 3'd0)
                    v = a - b;
                else if (f7 == rvde_pkg::F7_ALT && f3 == 3'd5)
                    v = $signed(a) >>> bs6;
                else if (f7 == rvde_pkg::F7_MULDIV)
                    use_md = 1'b1;
                else
                    ill = 1'b1;
            end
            rvde_pkg::OP_REG32:
            begin
                wr = 1'b1;
                if (f7 == rvde_pkg::F7_BASE && f3 == 3'd0)
                    v = rvde_pkg::sx32(a + b);
                else if (f7 == rvde_pkg::F7_BASE && f3 == 3'd1)
                    v = rvde_pkg::sx32(a << bs5);
                else if (f7 == rvde_pkg::F7_BASE && f3 == 3'd5)
                    v = rvde_pkg::sx32(a32 >> bs5);
                else if (f7 == rvde_pkg::F7_ALT && f3 == 3'd0)
                    v = rvde_pkg::sx32(a - b);
                else if (f7 == rvde_pkg::F7_ALT && f3 == 3'd5)
                    v = rvde_pkg::sx32($signed(rvde_pkg::sx32(a)) >>> bs5);
                else if (f7 == rvde_pkg::F7_MULDIV && (f3 == 3'd0 || f3[2]))
                    use_md = 1'b1;
                else
                    ill = 1'b1;
            end
            rvde_pkg::OP_IMM:
            begin
                wr = 1'b1;
                unique case (f3)
                    3'd0: v = a + imm_i;
                    3'd1:
                        if (f6 == rvde_pkg::F6_BASE)
                            v = a << sh6;
                        else
                            ill = 1'b1;
                    3'd2: v = {63'd0, ($signed(a) < $signed(imm_i))};
                    3'd3: v = {63'd0, (a < imm_i)};
                    3'd4: v = a ^ imm_i;
                    3'd5:
                        if (f6 == rvde_pkg::F6_BASE)
                            v = a >> sh6;
                        else if (f6 == rvde_pkg::F6_ALT)
                            v = $signed(a) >>> sh6;
                        else
                            ill = 1'b1;
                    3'd6: v = a | imm_i;
                    default: v = a & imm_i;
                endcase
            end
            rvde_pkg::OP_IMM32:
            begin
                wr = 1'b1;
                if (f3 == 3'd0)
                    v = rvde_pkg::sx32(a + imm_i);
                else if (f3 == 3'd1 && f7 == rvde_pkg::F7_BASE)
                    v = rvde_pkg::sx32(a << sh5);
                else if (f3 == 3'd5 && f7 == rvde_pkg::F7_BASE)
                    v = rvde_pkg::sx32(a32 >> sh5);
                else if (f3 == 3'd5 && f7 == rvde_pkg::F7_ALT)
                    v = rvde_pkg::sx32($signed(rvde_pkg::sx32(a)) >>> sh5);
                else
                    ill = 1'b1;
            end
            rvde_pkg::OP_LOAD:
            begin
                if (f3 == 3'd7)
                    ill = 1'b1;
                else
                begin
                    dec_res.mem_op        = rvde_pkg::MEM_LOAD;
                    dec_res.mem_address   = a + imm_i;
                    dec_res.mem_size_log2 = f3[1:0];
                    dec_res.load_signed   = ~f3[2];
                end
            end
            rvde_pkg::OP_STORE:
            begin
                if (f3[2])
                    ill = 1'b1;
                else
                begin
                    has_rd                = 1'b0;
                    dec_res.mem_op        = rvde_pkg::MEM_STORE;
                    dec_res.mem_address   = a + imm_s;
                    dec_res.mem_size_log2 = f3[1:0];
                    dec_res.store_data    = b;
                end
            end
            rvde_pkg::OP_BRANCH:
            begin
                has_rd = 1'b0;
                unique case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = ($signed(a) < $signed(b));
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = (a < b);
                    3'd7: take = (a >= b);
                    default: ill = 1'b1;
                endcase
                if (take)
                    dec_res.next_pc = pc_reg + imm_b;
            end
            rvde_pkg::OP_JALR:
            begin
                if (f3 != 3'd0)
                    ill = 1'b1;
                else
                begin
                    wr              = 1'b1;
                    v               = pc_reg + 64'd4;
                    dec_res.next_pc = (a + imm_i) & ~64'd1;
                end
            end
            rvde_pkg::OP_JAL:
            begin
                wr              = 1'b1;
                v               = pc_reg + 64'd4;
                dec_res.next_pc = pc_reg + imm_j;
            end
            rvde_pkg::OP_LUI:
            begin
                wr = 1'b1;
                v  = imm_u;
            end
            rvde_pkg::OP_AUIPC:
            begin
                wr = 1'b1;
                v  = pc_reg + imm_u;
            end
            rvde_pkg::OP_SYSTEM:
            begin
                if (f3 == 3'd0)
                begin
                    has_rd = 1'b0;
                    if (ins_reg == rvde_pkg::INS_ECALL)
                    begin
                        // Trap into machine mode: save pc, push MIE into MPIE.
                        mepc_next   = pc_reg;
                        mcause_next = rvde_pkg::CAUSE_ECALL_M;
                        mstatus_next[rvde_pkg::MSTATUS_MPIE] = mstatus_reg[rvde_pkg::MSTATUS_MIE];
                        mstatus_next[rvde_pkg::MSTATUS_MIE]  = 1'b0;
                        mstatus_next[rvde_pkg::MSTATUS_MPP +: 2] = 2'b11;
                        dec_res.next_pc = {mtvec_reg[63:2], 2'b00};
                    end
                    else if (ins_reg == rvde_pkg::INS_EBREAK)
                    begin
                        dec_res.trap_kind = rvde_pkg::TRAP_EBREAK;
                        dec_res.next_pc   = pc_reg;
                    end
                    else if (ins_reg == rvde_pkg::INS_MRET)
                    begin
                        mstatus_next[rvde_pkg::MSTATUS_MIE]  = mstatus_reg[rvde_pkg::MSTATUS_MPIE];
                        mstatus_next[rvde_pkg::MSTATUS_MPIE] = 1'b1;
                        dec_res.next_pc = mepc_reg;
                    end
                    else
                        ill = 1'b1;
                end
                else if (!csr_ok || f3 == 3'd3 || f3 == 3'd4 || f3 == 3'd5)
                    ill = 1'b1;
                else
                begin
                    wr = 1'b1;
                    v  = csr_old;
                    unique case (f3)
                        rvde_pkg::CSR_RW:  csr_new = a;
                        rvde_pkg::CSR_RS:  csr_new = csr_old | a;
                        rvde_pkg::CSR_RSI: csr_new = csr_old | {59'd0, zimm};
                        default:           csr_new = csr_old & ~{59'd0, zimm};
                    endcase
                    unique case (csr_addr)
                        rvde_pkg::CSR_MSTATUS: mstatus_next = csr_new;
                        rvde_pkg::CSR_MIE:     mie_next     = csr_new;
                        rvde_pkg::CSR_MTVEC:   mtvec_next   = csr_new;
                        rvde_pkg::CSR_MEPC:    mepc_next    = csr_new;
                        rvde_pkg::CSR_MCAUSE:  mcause_next  = csr_new;
                        default:               mip_next     = csr_new;
                    endcase
                end
            end
            default:
                ill = 1'b1;
        endcase

        if (ill)
        begin
            // Illegal encodings report a trap and leave all state untouched.
            dec_res           = '0;
            dec_res.trap_kind = rvde_pkg::TRAP_ILLEGAL;
            dec_res.next_pc   = pc_reg;
            use_md            = 1'b0;
            mstatus_next      = mstatus_reg;
            mie_next          = mie_reg;
            mtvec_next        = mtvec_reg;
            mepc_next         = mepc_reg;
            mcause_next       = mcause_reg;
            mip_next          = mip_reg;
        end
        else
        begin
            dec_res.rd_index = has_rd ? rd : 5'd0;
            dec_res.rd_write = wr && (rd != 5'd0);
            dec_res.rd_value = dec_res.rd_write ? v : 64'd0;
        end
    end

    // Sequencer: capture, execute, optionally iterate, then offer the result.
    always_comb
    begin
        state_next   = state_reg;
        md_req.start = 1'b0;
        md_req.funct3 = f3;
        md_req.word  = (op == rvde_pkg::OP_REG32);
        unique case (state_reg)
            rvde_pkg::ST_IDLE:
                if (req.valid)
                    state_next = rvde_pkg::ST_EXEC;
            rvde_pkg::ST_EXEC:
                if (use_md)
                begin
                    md_req.start = 1'b1;
                    state_next   = rvde_pkg::ST_WAIT;
                end
                else
                    state_next = rvde_pkg::ST_OUT;
            rvde_pkg::ST_WAIT:
                if (md_done)
                    state_next = rvde_pkg::ST_OUT;
            rvde_pkg::ST_OUT:
                if (rsp.ready)
                    state_next = rvde_pkg::ST_IDLE;
            default:
                state_next = rvde_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rvde_pkg::ST_IDLE;
            mstatus_reg <= '0;
            mie_reg     <= '0;
            mtvec_reg   <= '0;
            mepc_reg    <= '0;
            mcause_reg  <= '0;
            mip_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rvde_pkg::ST_EXEC)
            begin
                mstatus_reg <= mstatus_next;
                mie_reg     <= mie_next;
                mtvec_reg   <= mtvec_next;
                mepc_reg    <= mepc_next;
                mcause_reg  <= mcause_next;
                mip_reg     <= mip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rvde_pkg::ST_IDLE && req.valid)
        begin
            ins_reg <= req.instruction;
            pc_reg  <= req.pc;
            a_reg   <= req.rs1_value;
            b_reg   <= req.rs2_value;
        end
        if (state_reg == rvde_pkg::ST_EXEC)
            res_reg <= dec_res;
        else if (state_reg == rvde_pkg::ST_WAIT && md_done)
            res_reg.rd_value <= res_reg.rd_write ? md_result : 64'd0;
    end

    rvde_muldiv u_muldiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (a_reg),
        .b      (b_reg),
        .done   (md_done),
        .result (md_result)
    );

    assign req.ready         = (state_reg == rvde_pkg::ST_IDLE);
    assign rsp.valid         = (state_reg == rvde_pkg::ST_OUT);
    assign rsp.rd_index      = res_reg.rd_index;
    assign rsp.rd_write      = res_reg.rd_write;
    assign rsp.rd_value      = res_reg.rd_value;
    assign rsp.next_pc       = res_reg.next_pc;
    assign rsp.mem_op        = res_reg.mem_op;
    assign rsp.mem_address   = res_reg.mem_address;
    assign rsp.mem_size_log2 = res_reg.mem_size_log2;
    assign rsp.load_signed   = res_reg.load_signed;
    assign rsp.store_data    = res_reg.store_data;
    assign rsp.trap_kind     = res_reg.trap_kind;

    // Only one item is in the block at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("input ready while a result is pending");

    // The shared unit finishes only while the sequencer waits for it.
    a_md_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == rvde_pkg::ST_WAIT))
        else $error("multiply/divide finished outside the wait state");

    // A register write never targets x0.
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.rd_write) |-> (rsp.rd_index != 5'd0))
        else $error("register write to x0");

    // An illegal instruction has no write and no memory request.
    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.trap_kind == rvde_pkg::TRAP_ILLEGAL)
            |-> (!rsp.rd_write && rsp.mem_op == rvde_pkg::MEM_NONE))
        else $error("illegal instruction produced side effects");

endmodule
